>>> rtl/core/nru_pkg.sv
// ----------------------------------------------------------------------------
// nru_pkg
// Shared constants and types for the NRU page replacement unit.
// ----------------------------------------------------------------------------
package nru_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int RND_W       = 16;
  localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int FIU_W       = 4;
  localparam int RI_W        = 8;
  localparam int FAULT_W     = 32;

  // modulo unit: bits retired per cycle
  localparam int MOD_BITS_PER_CYC = 4;
  localparam int MOD_CYCLES       = RND_W / MOD_BITS_PER_CYC;
  localparam int MOD_CNT_W        = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(8);
  localparam logic [RI_W-1:0]  RI_RESET  = RI_W'(5);

  typedef enum logic [0:0] {
    REG_FRAMES_IN_USE  = 1'b0,
    REG_RESET_INTERVAL = 1'b1
  } reg_idx_t;

  // ripple from frame to frame
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] cnt;
  } chain_t;

  // commit command broadcast to all frame cells
  typedef struct packed {
    logic commit;
    logic fault;
    logic clear_all;
  } cell_cmd_t;

endpackage

>>> rtl/core/nru_cell.sv
// ----------------------------------------------------------------------------
// nru_cell
// One frame: page tag, valid and use bit, with lookup and candidate ripple.
// ----------------------------------------------------------------------------
module nru_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [nru_pkg::FRAME_IDX_W-1:0]   cell_idx,
  input  logic [nru_pkg::CNT_W-1:0]         n_act,
  input  logic [nru_pkg::PAGE_BITS-1:0]     page_in,
  input  logic [nru_pkg::CNT_W-1:0]         pick,
  input  logic                              tgt,
  input  nru_pkg::cell_cmd_t                cmd,
  input  nru_pkg::chain_t                   chain_i,
  output nru_pkg::chain_t                   chain_o,
  output logic                              first_o,
  output logic                              sel_o,
  output logic [nru_pkg::PAGE_BITS-1:0]     page_o,
  output logic                              valid_o
);
  import nru_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic                 use_r;
  logic                 active;
  logic                 match;
  logic                 cand;

  assign active = {{(CNT_W-FRAME_IDX_W){1'b0}}, cell_idx} < n_act;
  assign match  = active & valid_r & (page_r == page_in);
  assign cand   = active & (~valid_r | ~use_r);

  assign first_o       = match & ~chain_i.found;
  assign chain_o.found = chain_i.found | match;
  assign chain_o.cnt   = chain_i.cnt + {{(CNT_W-1){1'b0}}, cand};
  assign sel_o         = cand & (chain_i.cnt == pick);
  assign page_o        = page_r;
  assign valid_o       = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      use_r   <= 1'b0;
    end else if (cmd.commit) begin
      if (cmd.clear_all) begin
        use_r <= 1'b0;
      end else if (tgt) begin
        use_r <= 1'b1;
      end
      if (tgt && cmd.fault) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.fault && tgt) begin
      page_r <= page_in;
    end
  end

endmodule

>>> rtl/core/nru_mod.sv
// ----------------------------------------------------------------------------
// nru_mod
// Iterative restoring remainder of the random value by the candidate count.
// ----------------------------------------------------------------------------
module nru_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nru_pkg::RND_W-1:0]   dividend,
  input  logic [nru_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [nru_pkg::CNT_W-1:0]   remainder
);
  import nru_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] step_r;
  logic [RND_W-1:0]     dvd_r;
  logic [RND_W-1:0]     dvd_nxt;
  logic [CNT_W-1:0]     div_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;

  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    logic [RND_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int k = 0; k < MOD_BITS_PER_CYC; k++) begin
      t = {r, d[RND_W-1]};
      d = {d[RND_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[CNT_W-1:0];
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/nru_page_replacement.sv
// ----------------------------------------------------------------------------
// nru_page_replacement
// Not-recently-used page replacement unit built as a row of frame cells.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a page number and a random value. The frame
// cells compare the page in parallel and ripple a hit flag and a running
// candidate count from frame 0 upward. On a miss with candidates the random
// value is reduced modulo the candidate count by a shared iterative unit
// retiring four bits a cycle; the pick then selects the frame to replace.
// One output beat per input beat: hit flag, frame, evicted page, fault total.
// One item is in flight at a time; in_ready returns the cycle after the
// result is loaded, so a new item is taken only once the last has committed.
// The result sits in an output register; a stalled receiver holds it there
// and the next item proceeds up to its commit, which waits for that slot.
// Reset (rst_n, synchronous) empties all frames, clears use bits, counters,
// and restores frames_in_use to 8 and reset_interval to 5. The APB-style port
// writes registers at 0x0 (frames_in_use) and 0x4 (reset_interval).
// ----------------------------------------------------------------------------
module nru_page_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nru_pkg::PAGE_BITS-1:0]   in_page_number,
  input  logic [nru_pkg::RND_W-1:0]       in_random_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [nru_pkg::FRAME_IDX_W-1:0] out_frame_used,
  output logic                            out_evicted_valid,
  output logic [nru_pkg::PAGE_BITS-1:0]   out_evicted_page,
  output logic [nru_pkg::FAULT_W-1:0]     out_fault_total,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nru_pkg::APB_AW-1:0]      paddr,
  input  logic [nru_pkg::APB_DW-1:0]      pwdata,
  output logic [nru_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import nru_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [FIU_W-1:0]     frames_in_use_r;
  logic [RI_W-1:0]      reset_interval_r;
  logic [CNT_W-1:0]     n_act;
  reg_idx_t             reg_sel;

  logic [PAGE_BITS-1:0] page_r;
  logic [RND_W-1:0]     rnd_r;
  logic                 hit_r;
  logic [MAX_FRAMES-1:0] hit_vec_r;
  logic [CNT_W-1:0]     cand_cnt_r;
  logic [CNT_W-1:0]     pick_r;
  logic [RI_W-1:0]      ref_cnt_r, ref_cnt_nxt;
  logic [FAULT_W-1:0]   fault_cnt_r, fault_cnt_nxt;
  logic                 clear_all;
  logic [RI_W-1:0]      ref_inc;
  logic [RI_W-1:0]      interval;

  chain_t               chain [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] first_vec;
  logic [MAX_FRAMES-1:0] sel_vec;
  logic [MAX_FRAMES-1:0] valid_vec;
  logic [PAGE_BITS-1:0] page_vec [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] tgt_vec;
  cell_cmd_t            cmd;

  logic                 mod_start;
  logic                 mod_done;
  logic [CNT_W-1:0]     mod_rem;

  logic                 commit;
  logic [FRAME_IDX_W-1:0] slot;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [FRAME_IDX_W-1:0] out_frame_r;
  logic                 out_ev_valid_r;
  logic [PAGE_BITS-1:0] out_ev_page_r;

  // configuration
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r  <= FIU_RESET;
      reset_interval_r <= RI_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_FRAMES_IN_USE:  frames_in_use_r  <= pwdata[FIU_W-1:0];
        REG_RESET_INTERVAL: reset_interval_r <= pwdata[RI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAMES_IN_USE:  prdata = {{(APB_DW-FIU_W){1'b0}}, frames_in_use_r};
      REG_RESET_INTERVAL: prdata = {{(APB_DW-RI_W){1'b0}}, reset_interval_r};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CNT_W'(1);
    end else if ({{(32-FIU_W){1'b0}}, frames_in_use_r} > 32'(MAX_FRAMES)) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use_r);
    end
  end

  // frame cells
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    nru_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (FRAME_IDX_W'(i)),
      .n_act    (n_act),
      .page_in  (page_r),
      .pick     (pick_r),
      .tgt      (tgt_vec[i]),
      .cmd      (cmd),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1]),
      .first_o  (first_vec[i]),
      .sel_o    (sel_vec[i]),
      .page_o   (page_vec[i]),
      .valid_o  (valid_vec[i])
    );
  end

  nru_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (rnd_r),
    .divisor   (chain[MAX_FRAMES].cnt),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign mod_start = (state_r == S_LOOK) && !chain[MAX_FRAMES].found &&
                     (chain[MAX_FRAMES].cnt != '0);

  // target frame and eviction
  always_comb begin
    if (hit_r) begin
      tgt_vec = hit_vec_r;
    end else if (cand_cnt_r == '0) begin
      tgt_vec = MAX_FRAMES'(1);
    end else begin
      tgt_vec = sel_vec;
    end
  end

  always_comb begin
    slot    = '0;
    ev_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (tgt_vec[i]) begin
        slot    = slot | FRAME_IDX_W'(i);
        ev_page = ev_page | page_vec[i];
      end
    end
    ev_valid = !hit_r && |(tgt_vec & valid_vec);
    if (!ev_valid) begin
      ev_page = '0;
    end
  end

  // counters
  assign interval    = (reset_interval_r == '0) ? RI_W'(1) : reset_interval_r;
  assign ref_inc     = ref_cnt_r + 1'b1;
  assign clear_all   = ref_inc >= interval;
  assign ref_cnt_nxt = clear_all ? '0 : ref_inc;
  assign fault_cnt_nxt = (hit_r || (&fault_cnt_r)) ? fault_cnt_r : fault_cnt_r + 1'b1;

  assign commit = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign cmd.commit    = commit;
  assign cmd.fault     = !hit_r;
  assign cmd.clear_all = clear_all;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = mod_start ? S_DIV : S_DONE;
      S_DIV:  if (mod_done) state_nxt = S_DONE;
      S_DONE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_cnt_r   <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        ref_cnt_r   <= ref_cnt_nxt;
        fault_cnt_r <= fault_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      page_r <= in_page_number;
      rnd_r  <= in_random_value;
    end
    if (state_r == S_LOOK) begin
      hit_r      <= chain[MAX_FRAMES].found;
      hit_vec_r  <= first_vec;
      cand_cnt_r <= chain[MAX_FRAMES].cnt;
    end
    if (mod_done) begin
      pick_r <= mod_rem;
    end
    if (commit) begin
      out_hit_r      <= hit_r;
      out_frame_r    <= slot;
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_page;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_used    = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = fault_cnt_r;

  // checks
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("more than one first-match frame");

  a_commit_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> $onehot(tgt_vec))
    else $error("commit without a single target frame");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !hit_r |=> fault_cnt_r != '0)
    else $error("fault total zero after a fault");

endmodule

>>> tb/nru_page_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nru_page_replacement_test
// Self-checking bench for the NRU page replacement unit. A directed table
// covers the field extremes, frame-count and interval corner values,
// duplicates and full tables. Random references over small working sets
// follow, under several register settings and idle profiles. Leading rows
// of the table carry their expected beat; a behavioral frame table predicts
// every other result beat, and each beat is compared field by field.
// ----------------------------------------------------------------------------
module nru_page_replacement_test;
  import nru_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENTS      = 5;
  localparam int SEG_REFS      = 100;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [PAGE_BITS-1:0]   ev_page;
    logic [FAULT_W-1:0]     faults;
  } nru_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    reg_idx_t             regsel;
    logic [15:0]          arg;
    logic [RND_W-1:0]     rnd;
    logic                 typed;
    nru_result_t          want;
  } dir_row_t;

  localparam nru_result_t NO_RES = '0;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [PAGE_BITS-1:0]   in_page_number;
  logic [RND_W-1:0]       in_random_value;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_used;
  logic                   out_evicted_valid;
  logic [PAGE_BITS-1:0]   out_evicted_page;
  logic [FAULT_W-1:0]     out_fault_total;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // frame table mirror
  logic [PAGE_BITS-1:0] frame_tag [MAX_FRAMES] = '{default: '0};
  bit                   frame_live [MAX_FRAMES] = '{default: 1'b0};
  bit                   frame_ref [MAX_FRAMES] = '{default: 1'b0};
  logic [RI_W-1:0]      ref_count = '0;
  logic [FAULT_W-1:0]   fault_count = '0;
  logic [FIU_W-1:0]     cfg_frames = FIU_RESET;
  logic [RI_W-1:0]      cfg_interval = RI_RESET;

  nru_result_t pending_results [$];
  int          errors = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_requests = 0;

  dir_row_t dir_table [27] = '{
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0000, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0, 32'd1}},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0, 32'd2}},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0000, 16'h04D2, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0, 32'd2}},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hFFFF, 16'h0000, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0, 32'd2}},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0005, 16'h0000, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0, 32'd3}},
    '{ROW_CFG, REG_RESET_INTERVAL, 16'h00FF, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES_IN_USE,  16'h0001, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0007, 16'h0003, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0008, 16'h0009, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0008, 16'hFFFF, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES_IN_USE,  16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hFFFF, 16'h0005, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES_IN_USE,  16'h000F, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hFFFF, 16'h0002, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h0005, 16'h0007, 1'b0, NO_RES},
    '{ROW_CFG, REG_RESET_INTERVAL, 16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h1234, 16'hFFFF, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h1234, 16'h0001, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hABCD, 16'h0008, 1'b0, NO_RES},
    '{ROW_CFG, REG_RESET_INTERVAL, 16'h00C8, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h00A0, 16'h0003, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h00B0, 16'h0011, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h00C0, 16'h0022, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h00A0, 16'h0033, 1'b0, NO_RES},
    '{ROW_CFG, REG_RESET_INTERVAL, 16'h0003, 16'h0000, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'h5555, 16'hAAAA, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES_IN_USE,  16'hAAAA, 16'h5555, 1'b0, NO_RES}
  };

  nru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .in_random_value   (in_random_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("nru_page_replacement verification failed");
    $finish;
  end

  // one reference against the mirrored frame table
  function automatic nru_result_t replace_page(logic [PAGE_BITS-1:0] page,
                                               logic [RND_W-1:0] rnd);
    nru_result_t r;
    int          n;
    int          j;
    int          cand;
    int          pick;
    int          seen;
    int          slot;
    bit          found;
    int unsigned interval;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    cand  = 0;
    seen  = 0;
    n = (cfg_frames == 0) ? 1 : (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_frames);
    for (j = 0; j < n && !found; j++) begin
      if (frame_live[j] && frame_tag[j] == page) begin
        found        = 1'b1;
        slot         = j;
        frame_ref[j] = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      for (j = 0; j < n; j++) begin
        if (!frame_live[j] || !frame_ref[j]) cand++;
      end
      if (cand > 0) begin
        pick = int'(rnd) % cand;
        for (j = 0; j < n; j++) begin
          if (!frame_live[j] || !frame_ref[j]) begin
            if (seen == pick) slot = j;
            seen++;
          end
        end
      end
      if (frame_live[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = frame_tag[slot];
      end
      frame_tag[slot]  = page;
      frame_live[slot] = 1'b1;
      frame_ref[slot]  = 1'b1;
      if (fault_count != '1) fault_count++;
    end
    r.frame  = slot[FRAME_IDX_W-1:0];
    r.faults = fault_count;
    interval = (cfg_interval == 0) ? 1 : cfg_interval;
    ref_count = ref_count + 1'b1;
    if (ref_count >= interval) begin
      frame_ref = '{default: 1'b0};
      ref_count = '0;
    end
    return r;
  endfunction

  task automatic send_ref(logic [PAGE_BITS-1:0] page, logic [RND_W-1:0] rnd,
                          logic typed, nru_result_t want);
    nru_result_t model_res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_page_number  <= page;
    in_random_value <= rnd;
    do @(posedge clk); while (!in_ready);
    model_res = replace_page(page, rnd);
    pending_results.push_back(typed ? want : model_res);
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FRAMES_IN_USE) cfg_frames = val[FIU_W-1:0];
    else cfg_interval = val[RI_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    nru_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual hit %0h frame %0h",
                 $time, out_hit, out_frame_used);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("frame_used", 32'(want.frame), 32'(out_frame_used));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(out_evicted_valid));
        check_field("evicted_page", 32'(want.ev_page), 32'(out_evicted_page));
        check_field("fault_total", want.faults, out_fault_total);
      end
    end
  end

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [PAGE_BITS-1:0] work_set [12];
    logic [PAGE_BITS-1:0] page;
    logic [31:0]          val;
    int                   ws_size;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_page_number  = '0;
    in_random_value = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain(SETTLE_CYCLES);
        write_reg(dir_table[i].regsel, {16'h0000, dir_table[i].arg});
      end else begin
        send_ref(dir_table[i].arg, dir_table[i].rnd, dir_table[i].typed, dir_table[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 14 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain(SETTLE_CYCLES);
        val = $urandom;
        case ($urandom_range(3))
          0: val[FIU_W-1:0] = 4'd1;
          1: val[FIU_W-1:0] = 4'd8;
          default: val[FIU_W-1:0] = FIU_W'($urandom_range(15));
        endcase
        write_reg(REG_FRAMES_IN_USE, val);
        val = $urandom;
        case ($urandom_range(3))
          0: val[RI_W-1:0] = 8'd255;
          1: val[RI_W-1:0] = RI_W'($urandom_range(4));
          default: val[RI_W-1:0] = RI_W'($urandom_range(255));
        endcase
        write_reg(REG_RESET_INTERVAL, val);
        ws_size = $urandom_range(2, 12);
        for (int k = 0; k < ws_size; k++) work_set[k] = PAGE_BITS'($urandom_range(65535));
        for (int item = 0; item < SEG_REFS; item++) begin
          if (seg == 2 && item == 50) begin
            if (phase == 1) drain(0);
            else hold_requests++;
          end
          if ($urandom_range(99) < 85) page = work_set[$urandom_range(ws_size - 1)];
          else page = PAGE_BITS'($urandom_range(65535));
          send_ref(page, RND_W'($urandom_range(65535)), 1'b0, NO_RES);
        end
      end
    end

    drain(2 * SETTLE_CYCLES);
    if (errors == 0) begin
      $display("nru_page_replacement verification clean");
    end else begin
      $display("nru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/nru_pkg.sv
rtl/core/nru_cell.sv
rtl/core/nru_mod.sv
rtl/core/nru_page_replacement.sv
tb/nru_page_replacement_test.sv
